// File: rtl/core/assert_macros.svh
// assertion macros for the checker file fefe_checker.sv
// expects signals named clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on the block clock, off while in reset
`define FEFE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// antecedent in one cycle, consequent in the next
`define FEFE_ASSERT_NEXT(label, ante, cons) \
    `FEFE_ASSERT(label, (ante) |=> (cons))

`endif

// File: rtl/core/fefe_pkg.sv
// fefe_pkg: shared types, field widths and constants of the fire frame engine
// no dependencies
`timescale 1ns / 1ps

package fefe_pkg;

    localparam int FEFE_MAX_WIDTH  = 256;
    localparam int FEFE_MAX_HEIGHT = 256;

    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam int ROW_W     = 9;
    localparam int COL_W     = 8;
    localparam int PIX_W     = 8;
    localparam int DRAW_W    = 32;
    localparam int BIT_CNT_W = $clog2(DRAW_W);
    localparam int RNG_ROT   = 7;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 9'd256;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 9'd256;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [PIX_W-1:0] SEED_FILL = 8'h20;
    localparam logic [PIX_W-1:0] HOT_SPOT  = 8'hff;

    localparam logic [DRAW_W-1:0] RNG_POOL_RST = 32'h12345678;
    localparam logic [DRAW_W-1:0] RNG_ADD_RST  = 32'h87654321;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_ROW_PRE0,
        ST_ROW_PRE1,
        ST_ROW_PRE2,
        ST_SWEEP,
        ST_SEED,
        ST_HOT_WAIT,
        ST_HOT_DIV,
        ST_HOT_WRITE
    } fefe_state_t;

    typedef enum logic [1:0] {
        RNG_STEP,
        RNG_ADD,
        RNG_FOLD,
        RNG_READY
    } rng_state_t;

    typedef struct packed {
        logic              ready;
        logic [1:0]        k;
        logic [DRAW_W-1:0] value;
    } rng_status_t;

endpackage

// File: rtl/core/fefe_ram.sv
// fefe_ram: generic RAM, one write port, two registered read ports
// no dependencies
`timescale 1ns / 1ps

module fefe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: rtl/core/fefe_rng.sv
// fefe_rng: rotate-xor-add draw generator, keeps one draw and its value mod 3 ready
// depends on fefe_pkg
`timescale 1ns / 1ps

module fefe_rng
    import fefe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    output rng_status_t status
);

    localparam int HALF_W = DRAW_W / 2;
    localparam int FOLD_W = HALF_W + 1;

    rng_state_t        state_reg, state_next;
    logic [DRAW_W-1:0] pool_reg;
    logic [DRAW_W-1:0] add_reg;
    logic [FOLD_W-1:0] fold_reg;
    logic [1:0]        k_reg;

    logic              do_step;
    logic              do_add;
    logic              do_fold;
    logic [DRAW_W-1:0] mixed;

    function automatic logic [1:0] mod3(input logic [FOLD_W-1:0] f);
        logic [9:0] s2;
        logic [5:0] s3;
        logic [4:0] s4;
        logic [2:0] s5;
        logic [1:0] r;
        s2 = 10'(f[FOLD_W-1:8]) + 10'(f[7:0]);
        s3 = 6'(s2[9:4]) + 6'(s2[3:0]);
        s4 = 5'(s3[5:2]) + 5'(s3[1:0]);
        s5 = 3'(s4[4:2]) + 3'(s4[1:0]);
        case (s5) inside
            3'd0, 3'd3, 3'd6: r = 2'd0;
            3'd1, 3'd4, 3'd7: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    assign mixed = pool_reg ^ {pool_reg[DRAW_W-RNG_ROT-1:0],
                               pool_reg[DRAW_W-1:DRAW_W-RNG_ROT]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            RNG_STEP:  state_next = RNG_ADD;
            RNG_ADD:   state_next = RNG_FOLD;
            RNG_FOLD:  state_next = RNG_READY;
            RNG_READY:
            begin
                if (take)
                begin
                    state_next = RNG_ADD;
                end
            end
            default:   state_next = RNG_STEP;
        endcase
    end

    always_comb
    begin
        do_step      = 1'b0;
        do_add       = 1'b0;
        do_fold      = 1'b0;
        status.ready = 1'b0;
        status.k     = k_reg;
        status.value = pool_reg;
        unique case (state_reg)
            RNG_STEP:  do_step = 1'b1;
            RNG_ADD:   do_add  = 1'b1;
            RNG_FOLD:  do_fold = 1'b1;
            RNG_READY:
            begin
                status.ready = 1'b1;
                do_step      = take;
            end
            default:   do_step = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RNG_STEP;
            pool_reg  <= RNG_POOL_RST;
            add_reg   <= RNG_ADD_RST;
        end
        else
        begin
            state_reg <= state_next;
            if (do_step)
            begin
                pool_reg <= mixed + add_reg;
            end
            if (do_add)
            begin
                add_reg <= add_reg + pool_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_add)
        begin
            fold_reg <= FOLD_W'(pool_reg[DRAW_W-1:HALF_W]) + FOLD_W'(pool_reg[HALF_W-1:0]);
        end
        if (do_fold)
        begin
            k_reg <= mod3(fold_reg);
        end
    end

endmodule

// File: rtl/core/fire_effect_frame_engine_unit.sv
// fire_effect_frame_engine_unit: fire image store with frame sweep and pixel read
// depends on fefe_pkg, fefe_ram, fefe_rng
`timescale 1ns / 1ps

// Items are taken when start is high and busy is low; each item gives one result on
// pixel and frame_done, marked by done for one cycle, which the receiver cannot stall.
// After reset the block clears all MAX_WIDTH*(MAX_HEIGHT+1) pixels of its image memory
// (65792 at the defaults), one pixel a cycle, with busy high; configuration writes are
// taken meanwhile. A read item registers its address, reads the image memory through
// its registered port and registers the pixel together with done. A frame item sweeps
// rows 0 to h-1 (w, h the width and height in force), fills row h with the seed value
// and places w/2 hot spots in it. Each row first fills its window in ROW_PRE0, ROW_PRE1
// and ROW_PRE2, then sweeps one pixel a cycle through the two read ports, holding while
// a nonzero pixel waits for a draw; each hot spot costs a 32-step remainder by w.

module fire_effect_frame_engine_unit
    import fefe_pkg::*;
#(
    parameter int MAX_WIDTH  = FEFE_MAX_WIDTH,
    parameter int MAX_HEIGHT = FEFE_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [ROW_W-1:0]     row,
    input  logic [COL_W-1:0]     col,
    output logic                 done,
    output logic [PIX_W-1:0]     pixel,
    output logic                 frame_done,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int DEPTH = MAX_WIDTH * (MAX_HEIGHT + 1);
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int CW    = (WW > CFG_W) ? WW : CFG_W;
    localparam int PW    = ROW_W + WW;

    fefe_state_t       state_reg, state_next;
    logic [AW-1:0]     clear_addr_reg;
    logic              done_reg;
    logic [CFG_W-1:0]  cfg_width_reg;
    logic [CFG_W-1:0]  cfg_height_reg;

    logic [PIX_W-1:0]  pixel_reg;
    logic              frame_done_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic              rd_in_range_reg;
    logic [HW-1:0]     row_reg;
    logic [WW-1:0]     col_reg;
    logic [AW-1:0]     top_reg;
    logic [AW-1:0]     below_reg;
    logic [PIX_W-1:0]  bm1_reg;
    logic [PIX_W-1:0]  b0_reg;
    logic [DRAW_W-1:0] div_reg;
    logic [WW-1:0]     rem_reg;
    logic [BIT_CNT_W-1:0] bit_cnt_reg;

    logic [CW-1:0]     w_ext;
    logic [CW-1:0]     w_clamp;
    logic [CFG_W-1:0]  h_clamp;
    logic [WW-1:0]     eff_w;
    logic [HW-1:0]     eff_h;

    logic [PW-1:0]     rd_prod;
    logic              rd_in_range;
    logic [AW-1:0]     rd_addr;

    logic [PIX_W+1:0]  sum;
    logic [PIX_W-1:0]  mean;
    logic              nz;
    logic [PIX_W:0]    adj;
    logic [PIX_W-1:0]  result;
    logic              stall;
    logic              advance;
    logic              last_col;
    logic              last_row;
    logic              last_seed;
    logic              last_hot;
    logic [WW:0]       trial;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic [AW-1:0]     ram_raddr_a;
    logic [AW-1:0]     ram_raddr_b;
    logic [PIX_W-1:0]  ram_rdata_a;
    logic [PIX_W-1:0]  ram_rdata_b;

    logic              rng_take;
    rng_status_t       rng_status;

    fefe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    fefe_rng u_rng (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (rng_take),
        .status (rng_status)
    );

    // geometry in force, saturated into range
    always_comb
    begin
        w_ext = CW'(cfg_width_reg);
        if (w_ext < CW'(3))
        begin
            w_clamp = CW'(3);
        end
        else if (w_ext > CW'(MAX_WIDTH))
        begin
            w_clamp = CW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = w_ext;
        end
        if (cfg_height_reg == '0)
        begin
            h_clamp = CFG_W'(1);
        end
        else if (cfg_height_reg > CFG_W'(MAX_HEIGHT))
        begin
            h_clamp = CFG_W'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = cfg_height_reg;
        end
    end

    assign eff_w = WW'(w_clamp);
    assign eff_h = HW'(h_clamp);

    assign rd_prod     = PW'(row) * PW'(eff_w);
    assign rd_in_range = (row <= ROW_W'(eff_h)) && (CW'(col) < CW'(eff_w));
    assign rd_addr     = rd_in_range ? AW'(rd_prod + PW'(col)) : '0;

    // mean of the pixel and the three below it, with random nudge
    assign sum    = (PIX_W+2)'(ram_rdata_a) + (PIX_W+2)'(bm1_reg)
                  + (PIX_W+2)'(b0_reg) + (PIX_W+2)'(ram_rdata_b);
    assign mean   = sum[PIX_W+1:2];
    assign nz     = (mean != '0);
    assign adj    = (PIX_W+1)'(mean) + (PIX_W+1)'(rng_status.k) - (PIX_W+1)'(1);
    assign result = !nz ? '0 : (adj[PIX_W] ? HOT_SPOT : adj[PIX_W-1:0]);

    assign stall     = nz && !rng_status.ready;
    assign last_col  = (col_reg == eff_w - WW'(2));
    assign last_row  = (row_reg == eff_h - HW'(1));
    assign last_seed = (col_reg == eff_w - WW'(1));
    assign last_hot  = (col_reg == (eff_w >> 1) - WW'(1));
    assign advance   = !stall && !last_col;
    assign trial     = {rem_reg, div_reg[DRAW_W-1]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clear_addr_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (kind == KIND_READ) ? ST_RD_ISSUE : ST_ROW_PRE0;
                end
            end
            ST_RD_ISSUE: state_next = ST_RD_DATA;
            ST_RD_DATA:  state_next = ST_IDLE;
            ST_ROW_PRE0: state_next = ST_ROW_PRE1;
            ST_ROW_PRE1: state_next = ST_ROW_PRE2;
            ST_ROW_PRE2: state_next = ST_SWEEP;
            ST_SWEEP:
            begin
                if (!stall && last_col)
                begin
                    state_next = last_row ? ST_SEED : ST_ROW_PRE0;
                end
            end
            ST_SEED:
            begin
                if (last_seed)
                begin
                    state_next = ST_HOT_WAIT;
                end
            end
            ST_HOT_WAIT:
            begin
                if (rng_status.ready)
                begin
                    state_next = ST_HOT_DIV;
                end
            end
            ST_HOT_DIV:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_HOT_WRITE;
                end
            end
            ST_HOT_WRITE: state_next = last_hot ? ST_IDLE : ST_HOT_WAIT;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = (state_reg != ST_IDLE);
        ram_we      = 1'b0;
        ram_waddr   = top_reg + AW'(col_reg);
        ram_wdata   = result;
        ram_raddr_a = '0;
        ram_raddr_b = '0;
        rng_take    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clear_addr_reg;
                ram_wdata = '0;
            end
            ST_RD_ISSUE: ram_raddr_a = rd_addr_reg;
            ST_ROW_PRE0: ram_raddr_b = below_reg;
            ST_ROW_PRE1: ram_raddr_b = below_reg + AW'(1);
            ST_ROW_PRE2:
            begin
                ram_raddr_a = top_reg + AW'(1);
                ram_raddr_b = below_reg + AW'(2);
            end
            ST_SWEEP:
            begin
                // on a stall the same pixel is fetched again
                ram_raddr_a = top_reg + AW'(col_reg) + AW'(advance);
                ram_raddr_b = below_reg + AW'(col_reg) + AW'(1) + AW'(advance);
                ram_we      = !stall;
                rng_take    = nz && rng_status.ready;
            end
            ST_SEED:
            begin
                ram_we    = 1'b1;
                ram_wdata = SEED_FILL;
            end
            ST_HOT_WAIT: rng_take = rng_status.ready;
            ST_HOT_WRITE:
            begin
                ram_we    = 1'b1;
                ram_waddr = top_reg + AW'(rem_reg);
                ram_wdata = HOT_SPOT;
            end
            default:     rng_take = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
            done_reg       <= 1'b0;
            cfg_width_reg  <= FRAME_WIDTH_RST;
            cfg_height_reg <= FRAME_HEIGHT_RST;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_RD_DATA) || (state_reg == ST_HOT_WRITE && last_hot);
            if (state_reg == ST_CLEAR)
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  cfg_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: cfg_height_reg <= cfg_data;
                    default:          cfg_width_reg  <= cfg_width_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rd_addr_reg     <= rd_addr;
                    rd_in_range_reg <= rd_in_range;
                    row_reg         <= '0;
                    top_reg         <= '0;
                    below_reg       <= AW'(eff_w);
                end
            end
            ST_RD_DATA:
            begin
                pixel_reg      <= rd_in_range_reg ? ram_rdata_a : '0;
                frame_done_reg <= 1'b0;
            end
            ST_ROW_PRE1: bm1_reg <= ram_rdata_b;
            ST_ROW_PRE2:
            begin
                b0_reg  <= ram_rdata_b;
                col_reg <= WW'(1);
            end
            ST_SWEEP:
            begin
                if (!stall)
                begin
                    bm1_reg <= b0_reg;
                    b0_reg  <= ram_rdata_b;
                    if (last_col)
                    begin
                        top_reg <= below_reg;
                        if (last_row)
                        begin
                            col_reg <= '0;
                        end
                        else
                        begin
                            row_reg   <= row_reg + HW'(1);
                            below_reg <= below_reg + AW'(eff_w);
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + WW'(1);
                    end
                end
            end
            ST_SEED:
            begin
                col_reg <= last_seed ? '0 : col_reg + WW'(1);
            end
            ST_HOT_WAIT:
            begin
                div_reg     <= rng_status.value;
                rem_reg     <= '0;
                bit_cnt_reg <= BIT_CNT_W'(DRAW_W - 1);
            end
            ST_HOT_DIV:
            begin
                // restoring remainder, one bit of the draw a cycle
                if (trial >= (WW+1)'(eff_w))
                begin
                    rem_reg <= WW'(trial - (WW+1)'(eff_w));
                end
                else
                begin
                    rem_reg <= WW'(trial);
                end
                div_reg     <= {div_reg[DRAW_W-2:0], 1'b0};
                bit_cnt_reg <= bit_cnt_reg - BIT_CNT_W'(1);
            end
            ST_HOT_WRITE:
            begin
                col_reg <= col_reg + WW'(1);
                if (last_hot)
                begin
                    pixel_reg      <= '0;
                    frame_done_reg <= 1'b1;
                end
            end
            default:
            begin
                pixel_reg <= pixel_reg;
            end
        endcase
    end

    assign done       = done_reg;
    assign pixel      = pixel_reg;
    assign frame_done = frame_done_reg;

endmodule

// File: rtl/core/fefe_checker.sv
// fefe_checker: port-level checks of the fire frame engine, bound to the top level
// depends on fefe_pkg, assert_macros.svh
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fefe_checker
    import fefe_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             kind,
    input logic             done,
    input logic [PIX_W-1:0] pixel,
    input logic             frame_done
);

    // one result per item, so done is never high in back-to-back cycles
    `FEFE_ASSERT(a_done_single, done |=> !done)

    // a result only comes out once the block is free again
    `FEFE_ASSERT(a_done_idle, done |-> !busy)

    `FEFE_ASSERT(a_frame_pixel_zero, (done && frame_done) |-> !(|pixel))

    `FEFE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

    // a read item is answered after ST_RD_ISSUE and ST_RD_DATA, with frame_done low
    `FEFE_ASSERT(a_read_latency, (start && !busy && kind == KIND_READ) |-> ##3 (done && !frame_done))

endmodule

bind fire_effect_frame_engine_unit fefe_checker u_fefe_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .kind       (kind),
    .done       (done),
    .pixel      (pixel),
    .frame_done (frame_done)
);

// File: bench/testbench.sv
// testbench for fire_effect_frame_engine_unit: directed and random frame and pixel-read
// items checked against an in-bench model of the fire image and its draw generator
// depends on fefe_pkg and the fire_effect_frame_engine_unit rtl
`timescale 1ns / 1ps

module testbench;
    import fefe_pkg::*;

    localparam int IMG_DEPTH    = FEFE_MAX_WIDTH * (FEFE_MAX_HEIGHT + 1);
    localparam int RANDOM_ITEMS = 85;
    localparam int PHASE_ITEMS  = 12;
    localparam int STALL_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 8;

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic             frame_done;
    } pixel_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 kind = KIND_READ;
    logic [ROW_W-1:0]     row = '0;
    logic [COL_W-1:0]     col = '0;
    logic                 done;
    logic [PIX_W-1:0]     pixel;
    logic                 frame_done;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]     cfg_data = '0;

    bit [PIX_W-1:0]       fire_img [0:IMG_DEPTH-1];
    logic [DRAW_W-1:0]    heat_pool = RNG_POOL_RST;
    logic [DRAW_W-1:0]    heat_add = RNG_ADD_RST;
    logic [CFG_W-1:0]     cfg_width = FRAME_WIDTH_RST;
    logic [CFG_W-1:0]     cfg_height = FRAME_HEIGHT_RST;

    pixel_result_t        pending_results [$];
    int unsigned          mismatches = 0;
    int unsigned          frames_checked = 0;
    int unsigned          reads_checked = 0;
    int unsigned          geometry_writes = 0;
    int unsigned          idle_cycles = 0;
    bit                   burst_mode = 1'b0;

    fire_effect_frame_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .row       (row),
        .col       (col),
        .done      (done),
        .pixel     (pixel),
        .frame_done(frame_done),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned eff_width();
        if (cfg_width < 3)
        begin
            return 3;
        end
        if (cfg_width > FEFE_MAX_WIDTH)
        begin
            return FEFE_MAX_WIDTH;
        end
        return 32'(cfg_width);
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height < 1)
        begin
            return 1;
        end
        if (cfg_height > FEFE_MAX_HEIGHT)
        begin
            return FEFE_MAX_HEIGHT;
        end
        return 32'(cfg_height);
    endfunction

    function automatic logic [DRAW_W-1:0] next_draw();
        logic [DRAW_W-1:0] p;
        p = heat_pool;
        p = p ^ {p[DRAW_W-1-RNG_ROT:0], p[DRAW_W-1:DRAW_W-RNG_ROT]};
        p = p + heat_add;
        heat_add = heat_add + p;
        heat_pool = p;
        return p;
    endfunction

    // advances the image model by one item and returns the result it gives
    function automatic pixel_result_t fire_predict(logic k, logic [ROW_W-1:0] r,
                                                   logic [COL_W-1:0] c);
        pixel_result_t res;
        int unsigned   w;
        int unsigned   h;
        int unsigned   top;
        int unsigned   below;
        int unsigned   sum;
        int unsigned   val;
        int unsigned   base;
        w = eff_width();
        h = eff_height();
        res.pixel = '0;
        res.frame_done = 1'b0;
        if (k == KIND_FRAME)
        begin
            for (int unsigned y = 0; y < h; y++)
            begin
                top = y * w;
                below = (y + 1) * w;
                for (int unsigned i = 0; i + 2 < w; i++)
                begin
                    sum = fire_img[top + 1 + i] + fire_img[below + i]
                        + fire_img[below + i + 1] + fire_img[below + i + 2];
                    val = sum >> 2;
                    if (val != 0)
                    begin
                        val = val + (next_draw() % 3) - 1;
                    end
                    if (val > 255)
                    begin
                        val = 255;
                    end
                    fire_img[top + 1 + i] = val[PIX_W-1:0];
                end
            end
            base = h * w;
            for (int unsigned i = 0; i < w; i++)
            begin
                fire_img[base + i] = SEED_FILL;
            end
            for (int unsigned i = 0; i < w / 2; i++)
            begin
                fire_img[base + (next_draw() % w)] = HOT_SPOT;
            end
            res.frame_done = 1'b1;
        end
        else if (r <= h && c < w)
        begin
            res.pixel = fire_img[r * w + c];
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // called just after a rising edge; returns just after one
    task automatic send_item(logic k, logic [ROW_W-1:0] r, logic [COL_W-1:0] c);
        int unsigned gap;
        start <= 1'b1;
        kind <= k;
        row <= r;
        col <= c;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        pending_results.push_back(fire_predict(k, r, c));
        gap = burst_mode ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0 || busy)
        begin
            @(posedge clk);
        end
    endtask

    task automatic set_geometry(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        cfg_we <= 1'b1;
        cfg_index <= REG_FRAME_WIDTH;
        cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_FRAME_HEIGHT;
        cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_width = w;
        cfg_height = h;
        geometry_writes++;
    endtask

    always @(posedge clk)
    begin
        pixel_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result with none expected, pixel %0h frame_done %0b",
                                          pixel, frame_done));
            end
            else
            begin
                want = pending_results.pop_front();
                if (pixel !== want.pixel)
                begin
                    report_mismatch($sformatf("pixel %0h, expected %0h", pixel, want.pixel));
                end
                if (frame_done !== want.frame_done)
                begin
                    report_mismatch($sformatf("frame_done %0b, expected %0b",
                                              frame_done, want.frame_done));
                end
                if (want.frame_done)
                begin
                    frames_checked++;
                end
                else
                begin
                    reads_checked++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // reads sent while the post-reset clear is still running, taken once it ends
    task automatic test_cleared_image();
        set_geometry(9'd256, 9'd256);
        send_item(KIND_READ, 9'd0, 8'd0);
        send_item(KIND_READ, 9'd256, 8'd255);
        drain_results();
    endtask

    task automatic test_full_frame();
        send_item(KIND_FRAME, 9'd0, 8'd0);
        send_item(KIND_READ, 9'd256, 8'd0);
        send_item(KIND_READ, 9'd256, 8'd255);
        send_item(KIND_READ, 9'd255, 8'd128);
        send_item(KIND_READ, 9'd257, 8'd0);
        send_item(KIND_READ, 9'd511, 8'd255);
        drain_results();
    endtask

    // out of range register values and geometry changes over a kept image
    task automatic test_clamped_geometry();
        set_geometry(9'd0, 9'd0);
        send_item(KIND_FRAME, 9'd511, 8'd255);
        send_item(KIND_READ, 9'd0, 8'd1);
        send_item(KIND_READ, 9'd1, 8'd2);
        send_item(KIND_READ, 9'd0, 8'd3);
        send_item(KIND_READ, 9'd2, 8'd0);
        drain_results();
        set_geometry(9'd511, 9'd2);
        send_item(KIND_FRAME, 9'd0, 8'd0);
        send_item(KIND_READ, 9'd2, 8'd255);
        send_item(KIND_READ, 9'd1, 8'd100);
        drain_results();
        set_geometry(9'd3, 9'd511);
        send_item(KIND_FRAME, 9'd0, 8'd0);
        send_item(KIND_READ, 9'd256, 8'd1);
        send_item(KIND_READ, 9'd255, 8'd1);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int unsigned      sent;
        int unsigned      w;
        int unsigned      h;
        int unsigned      lo;
        int unsigned      pick;
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % PHASE_ITEMS == 0)
            begin
                drain_results();
                burst_mode = ($urandom_range(0, 2) == 0);
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    set_geometry(CFG_W'($urandom_range(3, 24)), CFG_W'($urandom_range(1, 16)));
                end
                else if (pick == 6)
                begin
                    set_geometry(CFG_W'($urandom_range(0, 2)), CFG_W'($urandom_range(0, 511)));
                end
                else if (pick == 7)
                begin
                    set_geometry(CFG_W'($urandom_range(25, 511)), CFG_W'($urandom_range(0, 4)));
                end
                else if (pick == 8)
                begin
                    set_geometry(CFG_W'($urandom_range(3, 8)), CFG_W'($urandom_range(17, 511)));
                end
                else
                begin
                    set_geometry(CFG_W'($urandom_range(3, 24)), 9'd0);
                end
            end
            w = eff_width();
            h = eff_height();
            if ($urandom_range(0, 99) < 35)
            begin
                send_item(KIND_FRAME, ROW_W'($urandom_range(0, 511)),
                          COL_W'($urandom_range(0, 255)));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    lo = (h > 3) ? h - 3 : 0;
                    r = ROW_W'($urandom_range(lo, h));
                end
                else if (pick < 85)
                begin
                    r = ROW_W'($urandom_range(0, h));
                end
                else
                begin
                    r = ROW_W'($urandom_range(0, 511));
                end
                if ($urandom_range(0, 4) != 0)
                begin
                    c = COL_W'($urandom_range(0, w - 1));
                end
                else
                begin
                    c = COL_W'($urandom_range(0, 255));
                end
                send_item(KIND_READ, r, c);
            end
            sent++;
        end
        drain_results();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_cleared_image();
        test_full_frame();
        test_clamped_geometry();
        test_random_traffic();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("checked %0d frame items and %0d pixel reads over %0d geometry settings",
                 frames_checked, reads_checked, geometry_writes);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
